// ===== hw/rtl/ccfd_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-checked frame deframer package
// Shared constants, header position codes and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package ccfd_pkg;

    localparam logic [7:0]  START_BYTE = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // Header byte positions within a frame, after the start byte
    localparam logic [3:0] POS_TYPE     = 4'd0;
    localparam logic [3:0] POS_ADDR_HI  = 4'd1;
    localparam logic [3:0] POS_ADDR_LO  = 4'd2;
    localparam logic [3:0] POS_MODE     = 4'd3;
    localparam logic [3:0] POS_SPARE    = 4'd4;
    localparam logic [3:0] POS_LENGTH   = 4'd5;
    localparam logic [3:0] POS_CRC_HI   = 4'd6;
    localparam logic [3:0] POS_CRC_LO   = 4'd7;
    localparam logic [3:0] POS_PAYLOAD  = 4'd8;

    // Reflected CRC-16 (Modbus) update by one byte, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/crc_checked_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// CRC-checked frame deframer
// Hunts for a start byte, captures an eight-byte header, streams payload
// bytes out and reports the Modbus CRC-16 check at frame end.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  -------------------------------
//  in        sink       i_in_valid / o_in_stall   i_data_byte
//  out       source     o_out_valid / i_out_stall o_out_byte .. o_payload_len
//  cfg       sink       i_cfg_wr_en               i_cfg_wr_data (replay mode)
//
//  One byte per cycle sustained while the output is not stalled. A byte
//  is held in the input register, is decoded and folded into the CRC by the
//  eight-step byte update, and its result (if any) is then written into
//  the output register.
//  Reset is synchronous and active low; it clears all frame state and the
//  replay mode register and returns the block to hunting.
//  A stalled output register holds the byte in the input register, which in
//  turn raises o_in_stall.
//
module crc_checked_frame_deframer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_payload,
    output logic [7:0] o_payload_index,
    output logic       o_frame_end,
    output logic       o_crc_ok,
    output logic       o_accepted,
    output logic [7:0] o_frame_type,
    output logic [15:0] o_dest_addr,
    output logic [7:0] o_payload_len,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data
);
    import ccfd_pkg::*;

    // Configuration
    logic r_replay_mode;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Frame state
    logic        r_in_frame,  n_in_frame;
    logic [3:0]  r_pos,       n_pos;
    logic [7:0]  r_cnt,       n_cnt;
    logic [7:0]  r_len,       n_len;
    logic [7:0]  r_type,      n_type;
    logic [15:0] r_addr,      n_addr;
    logic [15:0] r_rx_crc,    n_rx_crc;
    logic [15:0] r_crc,       n_crc;

    // Output register
    logic        r_out_vld;
    logic [7:0]  r_out_byte;
    logic        r_is_payload;
    logic [7:0]  r_index;
    logic        r_end;
    logic        r_ok;
    logic        r_acc;
    logic [7:0]  r_o_type;
    logic [15:0] r_o_addr;
    logic [7:0]  r_o_len;

    // Decode of the byte held in the input register
    logic       proceed;
    logic       emit;
    logic       payload;
    logic       frame_done;
    logic       crc_match;
    logic [7:0] idx;
    logic [7:0] cnt_inc;
    logic [7:0] crc_byte;

    // Process the held byte only when the output register is free or emptying
    assign proceed    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !proceed;

    assign cnt_inc = r_cnt + 8'd1;

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_type     = r_type;
        n_addr     = r_addr;
        n_rx_crc   = r_rx_crc;
        n_crc      = r_crc;
        emit       = 1'b0;
        payload    = 1'b0;
        frame_done = 1'b0;
        idx        = 8'd0;
        crc_byte   = r_in_byte;

        if (!r_in_frame) begin
            // Hunt: drop anything but the start byte
            if (r_in_byte == START_BYTE) begin
                n_in_frame = 1'b1;
                n_pos      = POS_TYPE;
                n_cnt      = 8'd0;
                n_crc      = crc_feed(CRC_INIT, r_in_byte);
            end
        end else if (r_pos != POS_PAYLOAD) begin
            case (r_pos)
                POS_TYPE:    n_type          = r_in_byte;
                POS_ADDR_HI: n_addr[15:8]    = r_in_byte;
                POS_ADDR_LO: n_addr[7:0]     = r_in_byte;
                POS_LENGTH:  n_len           = r_in_byte;
                POS_CRC_HI:  n_rx_crc[15:8]  = r_in_byte;
                POS_CRC_LO:  n_rx_crc[7:0]   = r_in_byte;
                default: ;
            endcase
            // CRC bytes enter the running CRC as zero
            if (r_pos == POS_CRC_HI || r_pos == POS_CRC_LO) begin
                crc_byte = 8'd0;
            end
            n_crc = crc_feed(r_crc, crc_byte);
            // Empty frame: end on the second CRC byte
            if (r_pos == POS_CRC_LO && r_len == 8'd0) begin
                emit       = 1'b1;
                frame_done = 1'b1;
            end
            n_pos = r_pos + 4'd1;
        end else begin
            n_crc   = crc_feed(r_crc, r_in_byte);
            emit    = 1'b1;
            payload = 1'b1;
            idx     = r_cnt;
            n_cnt   = cnt_inc;
            if (cnt_inc == r_len) begin
                frame_done = 1'b1;
            end
        end

        if (frame_done) begin
            n_in_frame = 1'b0;
        end
    end

    assign crc_match = frame_done && (n_crc == n_rx_crc);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_replay_mode <= i_cfg_wr_data;
        end
    end

    // Input register: load when empty or when its byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Frame state: advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= POS_TYPE;
            r_cnt      <= 8'd0;
            r_len      <= 8'd0;
            r_type     <= 8'd0;
            r_addr     <= 16'd0;
            r_rx_crc   <= 16'd0;
            r_crc      <= CRC_INIT;
        end else if (proceed) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_type     <= n_type;
            r_addr     <= n_addr;
            r_rx_crc   <= n_rx_crc;
            r_crc      <= n_crc;
        end
    end

    // Output register: fill on a result, drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proceed && emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && emit) begin
            r_out_byte   <= payload ? r_in_byte : 8'd0;
            r_is_payload <= payload;
            r_index      <= idx;
            r_end        <= frame_done;
            r_ok         <= crc_match;
            r_acc        <= crc_match && !r_replay_mode;
            r_o_type     <= n_type;
            r_o_addr     <= n_addr;
            r_o_len      <= n_len;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_byte      = r_out_byte;
    assign o_is_payload    = r_is_payload;
    assign o_payload_index = r_index;
    assign o_frame_end     = r_end;
    assign o_crc_ok        = r_ok;
    assign o_accepted      = r_acc;
    assign o_frame_type    = r_o_type;
    assign o_dest_addr     = r_o_addr;
    assign o_payload_len   = r_o_len;

    // A frame is only accepted at its end with a good CRC
    a_accept_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_acc |-> r_ok && r_end)
        else $error("accepted without CRC match at frame end");

    // A non-payload result only closes an empty frame
    a_empty_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_is_payload |-> r_end && (r_o_len == 8'd0))
        else $error("header result outside an empty frame");

    // Payload results only come from the payload phase
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_is_payload |-> r_pos == POS_PAYLOAD)
        else $error("payload result outside payload phase");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame deframer testbench
// Feeds byte streams of well-formed, corrupted and truncated frames with idle
// noise between them, predicts every result from an independent model of the
// hunting, header capture and CRC-16 check, and compares each result.
// ----------------------------------------------------------------------------
module testbench;
    import ccfd_pkg::*;

    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 6;     // input and output register plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
    localparam int PHASE_ITEMS    = 500;
    localparam int NUM_PHASES     = 4;
    localparam int NO_CUT         = 1000;  // longer than any frame

    // One result as seen on the output channel, in port order
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_payload;
        logic [7:0]  payload_index;
        logic        frame_end;
        logic        crc_ok;
        logic        accepted;
        logic [7:0]  frame_type;
        logic [15:0] dest_addr;
        logic [7:0]  payload_len;
    } deframe_result_t;

    // Tracks the frame state of the block and keeps the results still owed
    class frame_scoreboard;
        deframe_result_t owed_q[$];
        int          n_bad;
        logic        replay;
        logic        in_frame;
        logic [3:0]  position;
        logic [7:0]  count;
        logic [7:0]  length;
        logic [7:0]  ftype;
        logic [15:0] addr;
        logic [15:0] rx_crc;
        logic [15:0] run_crc;

        function new();
            n_bad    = 0;
            replay   = 1'b0;
            in_frame = 1'b0;
            position = POS_TYPE;
            count    = '0;
            length   = '0;
            ftype    = '0;
            addr     = '0;
            rx_crc   = '0;
            run_crc  = CRC_INIT;
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
            logic [15:0] c;
            logic        lsb;
            c = c_in ^ {8'h00, b};
            repeat (8) begin
                lsb = c[0];
                c   = c >> 1;
                if (lsb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void set_replay(input logic v);
            replay = v;
        endfunction

        function void note_byte(input logic [7:0] b);
            deframe_result_t r;
            logic            emit;
            logic            pay;
            logic            fin;
            logic            ok;
            logic [7:0]      idx;
            emit = 1'b0;
            pay  = 1'b0;
            fin  = 1'b0;
            idx  = '0;
            if (!in_frame) begin
                if (b == START_BYTE) begin
                    in_frame = 1'b1;
                    position = POS_TYPE;
                    count    = '0;
                    run_crc  = crc_step(CRC_INIT, b);
                end
                return;
            end
            case (position)
                POS_TYPE:    ftype        = b;
                POS_ADDR_HI: addr[15:8]   = b;
                POS_ADDR_LO: addr[7:0]    = b;
                POS_LENGTH:  length       = b;
                POS_CRC_HI:  rx_crc[15:8] = b;
                POS_CRC_LO:  rx_crc[7:0]  = b;
                default: ;
            endcase
            if (position < POS_PAYLOAD) begin
                // the CRC bytes themselves enter the sum as zero
                run_crc = crc_step(run_crc,
                                   (position == POS_CRC_HI || position == POS_CRC_LO) ? 8'h00 : b);
                if (position == POS_CRC_LO && length == 0) begin
                    emit = 1'b1;
                    fin  = 1'b1;
                end
                position = position + 1'b1;
            end else begin
                run_crc = crc_step(run_crc, b);
                emit    = 1'b1;
                pay     = 1'b1;
                idx     = count;
                count   = count + 1'b1;
                if (count == length) fin = 1'b1;
            end
            if (!emit) return;
            ok              = fin && (run_crc == rx_crc);
            r.out_byte      = pay ? b : 8'h00;
            r.is_payload    = pay;
            r.payload_index = idx;
            r.frame_end     = fin;
            r.crc_ok        = ok;
            r.accepted      = ok && !replay;
            r.frame_type    = ftype;
            r.dest_addr     = addr;
            r.payload_len   = length;
            owed_q.push_back(r);
            if (fin) in_frame = 1'b0;
        endfunction

        function void check_result(input deframe_result_t got);
            deframe_result_t want;
            if (owed_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("%0t: result with nothing owed: %p", $time, got);
                return;
            end
            want = owed_q.pop_front();
            if (got !== want) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("%0t: result mismatch", $time);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_is_payload;
    logic [7:0]  o_payload_index;
    logic        o_frame_end;
    logic        o_crc_ok;
    logic        o_accepted;
    logic [7:0]  o_frame_type;
    logic [15:0] o_dest_addr;
    logic [7:0]  o_payload_len;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;

    frame_scoreboard sb;

    int   burst_left   = 0;  // transactions left in the current sender burst
    int   gap_max      = 4;  // longest sender gap between bursts
    int   stall_max    = 0;  // longest receiver stall run, zero for none
    int   sent_items   = 0;  // frame bytes offered, idle noise excluded
    int   quiet_cycles = 0;
    logic stall_now    = 1'b0;
    int   stall_run    = 0;

    crc_checked_frame_deframer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_is_payload    (o_is_payload),
        .o_payload_index (o_payload_index),
        .o_frame_end     (o_frame_end),
        .o_crc_ok        (o_crc_ok),
        .o_accepted      (o_accepted),
        .o_frame_type    (o_frame_type),
        .o_dest_addr     (o_dest_addr),
        .o_payload_len   (o_payload_len),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    // 12 ns clock period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Output side: check each result transaction against the oldest one owed,
    // then pick the stall level for the next cycle. The stall pattern runs in
    // alternating stalled and free stretches of random length; the values read
    // here are the ones the block saw at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_out_byte, o_is_payload, o_payload_index, o_frame_end,
                             o_crc_ok, o_accepted, o_frame_type, o_dest_addr,
                             o_payload_len});
        end
        if (stall_max == 0) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_run <= 0) begin
                stall_now = !stall_now;
                stall_run = stall_now ? $urandom_range(1, stall_max)
                                      : $urandom_range(1, 3 * stall_max + 1);
            end
            stall_run--;
            i_out_stall <= stall_now;
        end
    end

    // Watchdog: give up once neither channel has moved for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** crc_checked_frame_deframer_unit: FAILED **");
            $finish;
        end
    end

    // Offer one byte and hold it until the block takes it. The sender works in
    // bursts; at the end of a burst drop valid and idle for a random gap.
    task automatic push_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_byte(b);
        burst_left--;
    endtask

    // Hold the sender until every owed result has arrived, then let the
    // pipeline settle in case the last bytes owed nothing
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.owed_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the block drained
    task automatic write_replay(input logic v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        sb.set_replay(v);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Build a frame with a correct or corrupted CRC and send its first
    // cut_at bytes; a cut frame leaves the block waiting for more
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] addr,
                              input int len, input bit good_crc,
                              input bit use_fill, input logic [7:0] fill,
                              input int cut_at);
        logic [7:0]  fr[$];
        logic [15:0] c;
        fr = {START_BYTE, ftype, addr[15:8], addr[7:0], 8'($urandom), 8'($urandom),
              8'(len), 8'h00, 8'h00};
        for (int i = 0; i < len; i++) fr.push_back(use_fill ? fill : 8'($urandom));
        c = CRC_INIT;
        foreach (fr[i]) c = frame_scoreboard::crc_step(c, fr[i]);
        if (!good_crc) c = c ^ 16'($urandom_range(1, 16'hFFFF));
        fr[7] = c[15:8];
        fr[8] = c[7:0];
        for (int i = 0; i < fr.size() && i < cut_at; i++) begin
            push_byte(fr[i]);
            sent_items++;
        end
    endtask

    // Mostly well-formed frames of short length with random content; the rest
    // is idle noise, corrupted CRCs and truncated frames
    task automatic random_phase(input int items, input bit with_longest);
        int start;
        int roll;
        int len;
        start = sent_items;
        if (with_longest) send_frame(8'($urandom), 16'($urandom), 255, 1'b1, 1'b0, 8'h00, NO_CUT);
        while (sent_items - start < items) begin
            if ($urandom_range(0, 4) == 0) push_byte(8'($urandom));
            roll = $urandom_range(0, 99);
            len  = (roll < 70) ? $urandom_range(0, 8)
                 : (roll < 95) ? $urandom_range(9, 40) : $urandom_range(41, 254);
            send_frame(8'($urandom), 16'($urandom), len, $urandom_range(0, 99) < 85,
                       1'b0, 8'h00,
                       ($urandom_range(0, 19) == 0) ? $urandom_range(1, 8) : NO_CUT);
            if ($urandom_range(0, 15) == 0) drain();
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= 8'h00;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_replay(1'b0);

        // Directed: idle bytes dropped, zero-length frame ending on its CRC
        // bytes with all-ones type and address, start byte inside a frame with a bad CRC
        stall_max = 2;
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(8'hFF, 16'hFFFF, 0, 1'b1, 1'b0, 8'h00, NO_CUT);
        send_frame(START_BYTE, 16'h0000, 2, 1'b0, 1'b1, START_BYTE, NO_CUT);
        drain();

        // Random phases: alternate replay mode and vary the idling on both sides
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            stall_max = (ph == 0) ? 3 : (ph == 1) ? 0 : (ph == 2) ? 12 : 1;
            gap_max   = (ph == 0) ? 4 : (ph == 1) ? 1 : (ph == 2) ? 10 : 2;
            write_replay(ph % 2 == 0);
            random_phase(PHASE_ITEMS, ph == 1 || ph == 2);
            drain();
        end

        if (sb.owed_q.size() != 0) $display("%0d results never arrived", sb.owed_q.size());
        if (sb.n_bad == 0 && sb.owed_q.size() == 0) begin
            $display("** crc_checked_frame_deframer_unit: PASSED **");
        end else begin
            $display("** crc_checked_frame_deframer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ccfd_pkg.sv
hw/rtl/crc_checked_frame_deframer_unit.sv
tb/testbench.sv
